@@ design/tlb_fl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlb_fl_pkg
// Shared types and constants for the fully associative TLB with FIFO / LRU
// replacement: beat structs, item kinds, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package tlb_fl_pkg;

  localparam int TLB_MAX_ENTRIES = 16;
  localparam int STAMP_W         = 32;
  localparam int CFG_DATA_W      = 5;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_FILL   = 2'd1,
    KIND_FLUSH  = 2'd2
  } tlb_kind_t;

  typedef enum logic [0:0] {
    CFG_ENTRIES_IN_USE = 1'b0,
    CFG_REPLACE_POLICY = 1'b1
  } cfg_reg_t;

  typedef enum logic [0:0] {
    POLICY_FIFO = 1'b0,
    POLICY_LRU  = 1'b1
  } policy_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_DONE
  } tlb_state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] proc_id;
    logic [7:0]  segment_num;
    logic [9:0]  page_num;
    logic [15:0] frame_in;
  } tlb_in_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] frame_out;
    logic [3:0]  slot;
    logic [4:0]  removed_count;
  } tlb_out_t;

  typedef struct packed {
    logic [15:0]        proc_id;
    logic [7:0]         segment_num;
    logic [9:0]         page_num;
    logic [15:0]        frame;
    logic [STAMP_W-1:0] stamp;
  } tlb_entry_t;

endpackage

`default_nettype wire

@@ design/tlb_fifo_lru_replacement_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tlb_fifo_lru_replacement_top
// Fully associative TLB: lookup, fill with FIFO or LRU victim, per-process
// flush with compaction. One entry RAM, one compare path, small sequencer.
// ----------------------------------------------------------------------------
// channel   signals                         direction  beat taken when
// item      start, busy, item               in         start && !busy
// result    done, result                    out        done (one cycle)
// config    cfg_valid, cfg_ready,           in         cfg_valid && cfg_ready
//           cfg_index, cfg_data
//
// Lookup and flush walk the valid entries one per cycle through the entry RAM
// read port (registered read); a lookup hit ends the walk early. A fill with
// room or FIFO victim goes from ST_FILL (write) to ST_DONE; an LRU fill first
// walks the valid entries in ST_SCAN to pick the victim.
// busy stays high from accept through the result cycle. Reset clears control
// state only; no RAM clearing pass. The receiver cannot stall.
// ----------------------------------------------------------------------------
module tlb_fifo_lru_replacement_top
  import tlb_fl_pkg::*;
#(
  parameter int MAX_ENTRIES = TLB_MAX_ENTRIES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire tlb_in_t               item,
  output logic                       done,
  output tlb_out_t                   result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [0:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CAP_W = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;

  // entry RAM
  tlb_entry_t mem [MAX_ENTRIES];
  tlb_entry_t rdata;
  logic [IDX_W-1:0] raddr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  tlb_entry_t       mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[raddr];
  end

  // config registers
  logic [CFG_DATA_W-1:0] entries_in_use;
  logic                  replace_policy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= CFG_DATA_W'(16);
      replace_policy <= POLICY_FIFO;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENTRIES_IN_USE: entries_in_use <= cfg_data;
        CFG_REPLACE_POLICY: replace_policy <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sequencer registers
  tlb_state_t         state, state_next;
  tlb_in_t            req, req_next;
  tlb_out_t           res, res_next;
  logic [CNT_W-1:0]   rd_idx, rd_idx_next;
  logic               chk_v, chk_v_next;
  logic [IDX_W-1:0]   chk_idx, chk_idx_next;
  logic [CNT_W-1:0]   kept, kept_next;
  logic [CNT_W-1:0]   removed, removed_next;
  logic [IDX_W-1:0]   best_idx, best_idx_next;
  logic [STAMP_W-1:0] best_stamp, best_stamp_next;
  logic [IDX_W-1:0]   wr_slot, wr_slot_next;
  logic [CNT_W-1:0]   entry_count, entry_count_next;
  logic [IDX_W-1:0]   fifo_pointer, fifo_pointer_next;
  logic [STAMP_W-1:0] stamp_counter, stamp_counter_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      chk_v         <= 1'b0;
      entry_count   <= '0;
      fifo_pointer  <= '0;
      stamp_counter <= '0;
    end else begin
      state         <= state_next;
      chk_v         <= chk_v_next;
      entry_count   <= entry_count_next;
      fifo_pointer  <= fifo_pointer_next;
      stamp_counter <= stamp_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    req        <= req_next;
    res        <= res_next;
    rd_idx     <= rd_idx_next;
    chk_idx    <= chk_idx_next;
    kept       <= kept_next;
    removed    <= removed_next;
    best_idx   <= best_idx_next;
    best_stamp <= best_stamp_next;
    wr_slot    <= wr_slot_next;
  end

  // capacity and FIFO victim
  logic [CAP_W-1:0] cap;
  logic [IDX_W-1:0] fifo_slot;
  logic [CAP_W-1:0] fifo_inc;

  always_comb begin
    if (CAP_W'(entries_in_use) > CAP_W'(MAX_ENTRIES)) begin
      cap = CAP_W'(MAX_ENTRIES);
    end else begin
      cap = CAP_W'(entries_in_use);
    end
    fifo_slot = (CAP_W'(fifo_pointer) < cap) ? fifo_pointer : '0;
    fifo_inc  = CAP_W'(fifo_slot) + CAP_W'(1);
  end

  logic issuing;
  logic scan_end;
  logic key_match;

  assign issuing   = (state == ST_SCAN) && (rd_idx < entry_count);
  assign scan_end  = (state == ST_SCAN) && !issuing && !chk_v;
  assign raddr     = issuing ? rd_idx[IDX_W-1:0] : '0;
  assign key_match = (rdata.proc_id == req.proc_id) &&
                     (rdata.segment_num == req.segment_num) &&
                     (rdata.page_num == req.page_num);

  always_comb begin
    state_next         = state;
    req_next           = req;
    res_next           = res;
    rd_idx_next        = issuing ? rd_idx + CNT_W'(1) : rd_idx;
    chk_v_next         = issuing;
    chk_idx_next       = rd_idx[IDX_W-1:0];
    kept_next          = kept;
    removed_next       = removed;
    best_idx_next      = best_idx;
    best_stamp_next    = best_stamp;
    wr_slot_next       = wr_slot;
    entry_count_next   = entry_count;
    fifo_pointer_next  = fifo_pointer;
    stamp_counter_next = stamp_counter;
    mem_we             = 1'b0;
    mem_waddr          = wr_slot;
    mem_wdata          = rdata;

    case (state)
      ST_IDLE: begin
        if (start) begin
          req_next     = item;
          res_next     = '0;
          rd_idx_next  = '0;
          chk_v_next   = 1'b0;
          kept_next    = '0;
          removed_next = '0;
          case (item.kind)
            KIND_LOOKUP, KIND_FLUSH: state_next = ST_SCAN;
            KIND_FILL: begin
              if (cap == '0) begin
                state_next = ST_DONE;
              end else if (CAP_W'(entry_count) < cap) begin
                wr_slot_next     = entry_count[IDX_W-1:0];
                entry_count_next = entry_count + CNT_W'(1);
                state_next       = ST_FILL;
              end else if (replace_policy == POLICY_FIFO) begin
                wr_slot_next      = fifo_slot;
                fifo_pointer_next = (fifo_inc >= cap) ? '0 : fifo_inc[IDX_W-1:0];
                state_next        = ST_FILL;
              end else begin
                state_next = ST_SCAN;
              end
            end
            default: state_next = ST_DONE;
          endcase
        end
      end

      ST_SCAN: begin
        case (req.kind)
          KIND_LOOKUP: begin
            if (chk_v && key_match) begin
              stamp_counter_next = stamp_counter + STAMP_W'(1);
              mem_we             = 1'b1;
              mem_waddr          = chk_idx;
              mem_wdata.stamp    = stamp_counter + STAMP_W'(1);
              res_next.hit       = 1'b1;
              res_next.frame_out = rdata.frame;
              res_next.slot      = 4'(chk_idx);
              state_next         = ST_DONE;
            end else if (scan_end) begin
              state_next = ST_DONE;
            end
          end
          KIND_FLUSH: begin
            if (chk_v) begin
              if (rdata.proc_id == req.proc_id) begin
                removed_next = removed + CNT_W'(1);
              end else begin
                // compaction: kept never passes the read pointer
                if (kept != CNT_W'(chk_idx)) begin
                  mem_we    = 1'b1;
                  mem_waddr = kept[IDX_W-1:0];
                end
                kept_next = kept + CNT_W'(1);
              end
            end
            if (scan_end) begin
              entry_count_next       = kept;
              res_next.removed_count = 5'(removed);
              state_next             = ST_DONE;
            end
          end
          default: begin
            // LRU victim: first entry with the smallest stamp
            if (chk_v && ((chk_idx == '0) || (rdata.stamp < best_stamp))) begin
              best_idx_next   = chk_idx;
              best_stamp_next = rdata.stamp;
            end
            if (scan_end) begin
              wr_slot_next = best_idx;
              state_next   = ST_FILL;
            end
          end
        endcase
      end

      ST_FILL: begin
        mem_we                = 1'b1;
        mem_waddr             = wr_slot;
        mem_wdata.proc_id     = req.proc_id;
        mem_wdata.segment_num = req.segment_num;
        mem_wdata.page_num    = req.page_num;
        mem_wdata.frame       = req.frame_in;
        mem_wdata.stamp       = stamp_counter;
        stamp_counter_next    = stamp_counter + STAMP_W'(1);
        res_next.slot         = 4'(wr_slot);
        state_next            = ST_DONE;
      end

      ST_DONE: begin
        state_next = ST_IDLE;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy   = (state != ST_IDLE);
  assign done   = (state == ST_DONE);
  assign result = res;

endmodule

`default_nettype wire
